### design/vrfa_pkg.sv
// ----------------------------------------------------------------------------
// vrfa_pkg
// Shared widths, instruction codes and controller command type for the
// register-file ALU.
// ----------------------------------------------------------------------------
package vrfa_pkg;

    localparam int DATA_W    = 8;
    localparam int IDX_W     = 4;
    localparam int KIND_W    = 4;
    localparam int REG_COUNT = 16;

    localparam logic [IDX_W-1:0] FLAG_INDEX = 4'hF;

    localparam logic [KIND_W-1:0] KIND_LD   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ADDI = 4'd1;
    localparam logic [KIND_W-1:0] KIND_CPY  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_OR   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_AND  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_XOR  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_ADD  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SUB  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SHR  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SUBN = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SHL  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_RND  = 4'd11;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  dest_index;
        logic [IDX_W-1:0]  src_index;
        logic [DATA_W-1:0] immediate;
        logic [DATA_W-1:0] random_byte;
    } instr_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic load;
    } ctrl_cmd_t;

endpackage

### design/vrfa_instr_if.sv
// ----------------------------------------------------------------------------
// vrfa_instr_if
// Instruction channel: valid/ready handshake with the instruction fields.
// ----------------------------------------------------------------------------
interface vrfa_instr_if
    import vrfa_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  dest_index;
    logic [IDX_W-1:0]  src_index;
    logic [DATA_W-1:0] immediate;
    logic [DATA_W-1:0] random_byte;

    modport source (
        output valid,
        output kind,
        output dest_index,
        output src_index,
        output immediate,
        output random_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  dest_index,
        input  src_index,
        input  immediate,
        input  random_byte,
        output ready
    );

endinterface

### design/vrfa_result_if.sv
// ----------------------------------------------------------------------------
// vrfa_result_if
// Result channel: valid/ready handshake with destination and flag values.
// ----------------------------------------------------------------------------
interface vrfa_result_if
    import vrfa_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] flag_value;

    modport source (
        output valid,
        output dest_value,
        output flag_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  dest_value,
        input  flag_value,
        output ready
    );

endinterface

### design/vrfa_ctrl.sv
// ----------------------------------------------------------------------------
// vrfa_ctrl
// Sequencer: accept an instruction, execute and write the flag, then write
// the destination and load the result register when it is free.
// ----------------------------------------------------------------------------
module vrfa_ctrl
    import vrfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      instr_valid,
    output logic      instr_ready,
    output logic      result_valid,
    input  logic      result_ready,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign instr_ready  = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign out_free     = !out_valid_reg || result_ready;

    assign cmd.accept = instr_ready && instr_valid;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.load   = (state_reg == S_WRITE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/vrfa_datapath.sv
// ----------------------------------------------------------------------------
// vrfa_datapath
// Register file with three read ports and one write port, operand registers,
// the 8-bit ALU and the result register.
// ----------------------------------------------------------------------------
module vrfa_datapath
    import vrfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  instr_t            instr,
    output logic [DATA_W-1:0] dest_value,
    output logic [DATA_W-1:0] flag_value
);

    logic [DATA_W-1:0]    rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  dx_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] rnd_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] r15_reg;
    logic [DATA_W-1:0] res_reg;
    logic              flag_bit_reg;
    logic [DATA_W-1:0] dest_value_reg;
    logic [DATA_W-1:0] flag_value_reg;

    logic [DATA_W-1:0] res_next;
    logic              flag_bit_next;
    logic [DATA_W:0]   sum;
    logic              is_write;
    logic              has_flag;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] flag_final;

    always_comb
    begin
        is_write = kind_reg inside {[KIND_LD:KIND_RND]};
        has_flag = kind_reg inside {KIND_ADD, KIND_SUB, KIND_SHR, KIND_SUBN, KIND_SHL};
    end

    assign sum = {1'b0, a_reg} + {1'b0, b_reg};

    always_comb
    begin
        res_next      = a_reg;
        flag_bit_next = 1'b0;
        case (kind_reg)
            KIND_LD:   res_next = imm_reg;
            KIND_ADDI: res_next = a_reg + imm_reg;
            KIND_CPY:  res_next = b_reg;
            KIND_OR:   res_next = a_reg | b_reg;
            KIND_AND:  res_next = a_reg & b_reg;
            KIND_XOR:  res_next = a_reg ^ b_reg;
            KIND_ADD:
            begin
                res_next      = sum[DATA_W-1:0];
                flag_bit_next = sum[DATA_W];
            end
            KIND_SUB:
            begin
                res_next      = a_reg - b_reg;
                flag_bit_next = (a_reg >= b_reg);
            end
            KIND_SHR:
            begin
                res_next      = {1'b0, a_reg[DATA_W-1:1]};
                flag_bit_next = a_reg[0];
            end
            KIND_SUBN:
            begin
                res_next      = b_reg - a_reg;
                flag_bit_next = (b_reg >= a_reg);
            end
            KIND_SHL:
            begin
                res_next      = {a_reg[DATA_W-2:0], 1'b0};
                flag_bit_next = a_reg[DATA_W-1];
            end
            KIND_RND:  res_next = rnd_reg & imm_reg;
            default:   res_next = a_reg;
        endcase
    end

    // flag goes in during execute, destination during write-back
    assign wr_en   = (cmd.exec && is_write && has_flag) || (cmd.load && is_write);
    assign wr_addr = cmd.exec ? FLAG_INDEX : dx_reg;
    assign wr_data = cmd.exec ? {{(DATA_W-1){1'b0}}, flag_bit_next} : res_reg;

    always_comb
    begin
        if (is_write && (dx_reg == FLAG_INDEX))
        begin
            flag_final = res_reg;
        end
        else if (is_write && has_flag)
        begin
            flag_final = {{(DATA_W-1){1'b0}}, flag_bit_reg};
        end
        else
        begin
            flag_final = r15_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
        if (cmd.accept)
        begin
            kind_reg <= instr.kind;
            dx_reg   <= instr.dest_index;
            imm_reg  <= instr.immediate;
            rnd_reg  <= instr.random_byte;
            a_reg    <= rf_valid_reg[instr.dest_index] ? rf_mem[instr.dest_index] : '0;
            b_reg    <= rf_valid_reg[instr.src_index] ? rf_mem[instr.src_index] : '0;
        end
        if (cmd.exec)
        begin
            r15_reg      <= rf_valid_reg[FLAG_INDEX] ? rf_mem[FLAG_INDEX] : '0;
            res_reg      <= res_next;
            flag_bit_reg <= flag_bit_next;
        end
        if (cmd.load)
        begin
            dest_value_reg <= res_reg;
            flag_value_reg <= flag_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            rf_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign dest_value = dest_value_reg;
    assign flag_value = flag_value_reg;

endmodule

### design/vm_register_file_alu.sv
// ----------------------------------------------------------------------------
// vm_register_file_alu
// Register-ALU instruction unit on sixteen 8-bit registers, register 15
// holding the flag. One result transfer per instruction transfer.
//
//   channel   modport   payload
//   instr     sink      kind, dest_index, src_index, immediate, random_byte
//   result    source    dest_value, flag_value
//
// An instruction steps through operand read, execute with flag write and
// destination write-back; the single register-file write port sets this.
// Reset clears the registers to zero at once through per-entry valid bits.
// The next instruction is taken while a result waits in the output register;
// a stalled result holds the write-back step until it is transferred.
// ----------------------------------------------------------------------------
module vm_register_file_alu
    import vrfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    vrfa_instr_if.sink   instr,
    vrfa_result_if.source result
);

    ctrl_cmd_t cmd;
    instr_t    instr_word;

    assign instr_word.kind        = instr.kind;
    assign instr_word.dest_index  = instr.dest_index;
    assign instr_word.src_index   = instr.src_index;
    assign instr_word.immediate   = instr.immediate;
    assign instr_word.random_byte = instr.random_byte;

    vrfa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr.valid),
        .instr_ready  (instr.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    vrfa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .instr      (instr_word),
        .dest_value (result.dest_value),
        .flag_value (result.flag_value)
    );

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.exec)
        else $error("execute did not follow instruction transfer");

    a_no_accept_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !instr.ready)
        else $error("instruction taken during write-back");

    a_accept_load_apart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.load)
        else $error("instruction transfer and result load coincide");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.load))
        else $error("result valid without a load");

endmodule
